@@ src/smvm_pkg.sv @@
// Shared constants for the segmented-memory machine core.
`timescale 1ns / 1ps
package smvm_pkg;
  localparam int MAX_SEGMENTS = 64;
  localparam int SEG_WORDS    = 1024;
  localparam int NUM_REGS     = 8;
  localparam int DATA_W       = 32;
  localparam int SEG_BITS     = $clog2(MAX_SEGMENTS);
  localparam int OFF_BITS     = $clog2(SEG_WORDS);
  localparam int ADDR_BITS    = SEG_BITS + OFF_BITS;
  localparam int LEN_BITS     = OFF_BITS + 1;
  localparam int SCNT_BITS    = SEG_BITS + 1;
  localparam int REG_BITS     = $clog2(NUM_REGS);
  localparam int DIV_CNT_BITS = $clog2(DATA_W) + 1;

  // Opcodes
  localparam logic [3:0] OP_CMOV    = 4'd0;
  localparam logic [3:0] OP_LOAD    = 4'd1;
  localparam logic [3:0] OP_STORE   = 4'd2;
  localparam logic [3:0] OP_ADD     = 4'd3;
  localparam logic [3:0] OP_MUL     = 4'd4;
  localparam logic [3:0] OP_DIV     = 4'd5;
  localparam logic [3:0] OP_NAND    = 4'd6;
  localparam logic [3:0] OP_HALT    = 4'd7;
  localparam logic [3:0] OP_MAP     = 4'd8;
  localparam logic [3:0] OP_UNMAP   = 4'd9;
  localparam logic [3:0] OP_OUT     = 4'd10;
  localparam logic [3:0] OP_IN      = 4'd11;
  localparam logic [3:0] OP_LOADPRG = 4'd12;
  localparam logic [3:0] OP_LOADVAL = 4'd13;

  // Run status codes
  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_HALT  = 2'd1;
  localparam logic [1:0] ST_END   = 2'd2;
  localparam logic [1:0] ST_FAULT = 2'd3;

  // Divider handshake
  typedef struct packed {
    logic done;
    logic busy;
  } div_stat_t;
endpackage

@@ src/smvm_ram.sv @@
// Generic simple dual-port RAM, registered read.
`timescale 1ns / 1ps
module smvm_ram #(
  parameter int WIDTH = 32,
  parameter int AW    = 16
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule

@@ src/smvm_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module smvm_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [smvm_pkg::DATA_W-1:0] dividend,
  input  logic [smvm_pkg::DATA_W-1:0] divisor,
  output logic [smvm_pkg::DATA_W-1:0] quot,
  output smvm_pkg::div_stat_t        stat
);
  logic [smvm_pkg::DATA_W-1:0]       rem;
  logic [smvm_pkg::DATA_W-1:0]       dsr;
  logic [smvm_pkg::DIV_CNT_BITS-1:0] cnt;
  logic [smvm_pkg::DATA_W:0]         shifted;
  logic [smvm_pkg::DATA_W:0]         diff;
  logic                              ge;

  // trial subtract of the shifted remainder
  assign shifted = {rem, quot[smvm_pkg::DATA_W-1]};
  assign diff    = shifted - {1'b0, dsr};
  assign ge      = shifted >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      // done pulses for one cycle after the last quotient bit
      stat.done <= !start && stat.busy && (cnt == smvm_pkg::DIV_CNT_BITS'(1));
      if (start) begin
        quot      <= dividend;
        dsr       <= divisor;
        rem       <= '0;
        cnt       <= smvm_pkg::DIV_CNT_BITS'(smvm_pkg::DATA_W);
        stat.busy <= 1'b1;
      end else if (stat.busy) begin
        rem  <= ge ? diff[smvm_pkg::DATA_W-1:0] : shifted[smvm_pkg::DATA_W-1:0];
        quot <= {quot[smvm_pkg::DATA_W-2:0], ge};
        cnt  <= cnt - 1'b1;
        if (cnt == smvm_pkg::DIV_CNT_BITS'(1)) begin
          stat.busy <= 1'b0;
        end
      end
    end
  end
endmodule

@@ src/segmented_memory_vm_core.sv @@
// Top level of the segmented-memory virtual machine core.
`timescale 1ns / 1ps
// An item with action 0 appends program_word to segment 0 while it has room; an item with
// action 1 executes one instruction. A step runs fetch, two register-file reads, a
// segment-table read and execute, an order set by the single read port of the word
// RAM and the two read ports of the register file. Loads add a load-wait state, divides
// wait for the divider (one quotient bit a cycle), map zero-fills the new segment word
// by word, and load program from a nonzero segment copies its words into segment 0.
// Stopped or past-end steps go straight to the result. One result is returned per
// item; a finished result waits in an output register so the next item can be taken
// meanwhile. No clearing pass is needed after reset.
module segmented_memory_vm_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [31:0] program_word,
  input  logic [7:0]  in_byte,
  input  logic        in_eof,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [1:0]  status,
  output logic        out_valid,
  output logic [7:0]  out_byte,
  output logic        in_taken,
  output logic [31:0] next_pc
);
  localparam int DW = smvm_pkg::DATA_W;
  localparam int SB = smvm_pkg::SEG_BITS;
  localparam int OB = smvm_pkg::OFF_BITS;
  localparam int AB = smvm_pkg::ADDR_BITS;
  localparam int LB = smvm_pkg::LEN_BITS;
  localparam int CB = smvm_pkg::SCNT_BITS;
  localparam int RB = smvm_pkg::REG_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_OPND, S_LEN, S_EXEC, S_LOADW, S_DIVW, S_FILL, S_COPY, S_DONE
  } state_t;

  state_t                   state;
  state_t                   exec_next;
  logic [DW-1:0]            pc;
  logic [LB-1:0]            pl;
  logic [1:0]               run;
  logic [CB-1:0]            created;
  logic [CB-1:0]            fc;
  logic [smvm_pkg::MAX_SEGMENTS-1:0] mapped;
  logic [DW-1:0]            instr;
  logic [DW-1:0]            ra, rb, rc;
  logic [LB-1:0]            cnt;
  logic [LB-1:0]            xfer_len;
  logic [OB-1:0]            wcnt;
  logic                     cp_pend;
  logic [SB-1:0]            map_id;
  logic [SB-1:0]            src;
  logic                     item_ov, item_tk;
  logic [7:0]               item_ob;
  logic [7:0]               a_byte;
  logic                     a_eof;

  // word RAM ports
  logic          ram_we;
  logic [AB-1:0] ram_waddr, ram_raddr;
  logic [DW-1:0] ram_wdata, ram_q;
  // segment length table ports
  logic          len_we;
  logic [SB-1:0] len_waddr, len_raddr;
  logic [LB-1:0] len_wdata, len_q;
  // free identifier stack ports
  logic          stk_we;
  logic [SB-1:0] stk_waddr, stk_raddr, stk_wdata, stk_q;
  // register file
  logic [DW-1:0] rf [smvm_pkg::NUM_REGS];
  logic          rf_we;
  logic [RB-1:0] rf_wa, rf_ra0, rf_ra1;
  logic [DW-1:0] rf_wd, rf_q0, rf_q1;
  // divider
  logic                div_start;
  logic [DW-1:0]       div_quot;
  smvm_pkg::div_stat_t div_stat;

  logic [3:0]    op;
  logic [RB-1:0] fa, fb, fc_idx;
  logic [DW-1:0] seg_sel, off_sel;
  logic [SB-1:0] seg_idx;
  logic [LB-1:0] len_eff;
  logic          in_bnd;
  logic          map_ok;
  logic [SB-1:0] new_id;
  logic          unmap_bad;
  logic          out_load;

  assign op     = instr[31:28];
  assign fa     = instr[8:6];
  assign fb     = instr[5:3];
  assign fc_idx = instr[2:0];

  assign in_stall = (state != S_IDLE);

  // bounds check of segment access, store uses A/B, load uses B/C
  assign seg_sel = (op == smvm_pkg::OP_STORE) ? ra : rb;
  assign off_sel = (op == smvm_pkg::OP_STORE) ? rb : rc;
  assign seg_idx = seg_sel[SB-1:0];
  assign len_eff = (seg_idx == '0) ? pl : (mapped[seg_idx] ? len_q : '0);
  assign in_bnd  = (seg_sel[DW-1:SB] == '0) && mapped[seg_idx] &&
                   (off_sel < {{(DW-LB){1'b0}}, len_eff});

  // identifier allocation
  assign new_id    = (fc != '0) ? stk_q : created[SB-1:0];
  assign map_ok    = (rc <= DW'(smvm_pkg::SEG_WORDS)) &&
                     ((fc != '0) || (created < CB'(smvm_pkg::MAX_SEGMENTS)));
  assign unmap_bad = (rc == '0) || (rc >= DW'(smvm_pkg::MAX_SEGMENTS)) ||
                     !mapped[rc[SB-1:0]] || (fc >= CB'(smvm_pkg::MAX_SEGMENTS));

  assign div_start = (state == S_EXEC) && (op == smvm_pkg::OP_DIV) && (rc != '0);
  assign out_load  = (state == S_DONE) && (!res_valid || !res_stall);

  // state after execute: multi-cycle instructions branch off, the rest finish
  always_comb begin
    exec_next = S_DONE;
    case (op)
      smvm_pkg::OP_LOAD: begin
        if (in_bnd) begin
          exec_next = S_LOADW;
        end
      end
      smvm_pkg::OP_DIV: begin
        if (rc != '0) begin
          exec_next = S_DIVW;
        end
      end
      smvm_pkg::OP_MAP: begin
        if (map_ok && (rc != '0)) begin
          exec_next = S_FILL;
        end
      end
      smvm_pkg::OP_LOADPRG: begin
        if ((rb != '0) && (rb[DW-1:SB] == '0) && mapped[rb[SB-1:0]]) begin
          exec_next = S_COPY;
        end
      end
      default: begin
      end
    endcase
  end

  // memory port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = {{SB{1'b0}}, pc[OB-1:0]};
    len_we    = 1'b0;
    len_waddr = new_id;
    len_wdata = rc[LB-1:0];
    len_raddr = rb[SB-1:0];
    stk_we    = 1'b0;
    stk_waddr = fc[SB-1:0];
    stk_wdata = rc[SB-1:0];
    stk_raddr = fc[SB-1:0] - 1'b1;
    rf_we     = 1'b0;
    rf_wa     = fa;
    rf_wd     = '0;
    rf_ra0    = ram_q[5:3];
    rf_ra1    = ram_q[2:0];
    case (state)
      S_IDLE: begin
        if (in_valid && !action && (pl < LB'(smvm_pkg::SEG_WORDS))) begin
          ram_we    = 1'b1;
          ram_waddr = {{SB{1'b0}}, pl[OB-1:0]};
          ram_wdata = program_word;
        end
      end
      S_OPND: begin
        rf_ra0 = fa;
      end
      S_LEN: begin
        len_raddr = (op == smvm_pkg::OP_STORE) ? rf_q0[SB-1:0] : rb[SB-1:0];
      end
      S_EXEC: begin
        ram_raddr = {rb[SB-1:0], rc[OB-1:0]};
        case (op)
          smvm_pkg::OP_CMOV: begin
            rf_we = (rc != '0);
            rf_wd = rb;
          end
          smvm_pkg::OP_STORE: begin
            ram_we    = in_bnd;
            ram_waddr = {ra[SB-1:0], rb[OB-1:0]};
            ram_wdata = rc;
          end
          smvm_pkg::OP_ADD: begin
            rf_we = 1'b1;
            rf_wd = rb + rc;
          end
          smvm_pkg::OP_MUL: begin
            rf_we = 1'b1;
            rf_wd = rb * rc;
          end
          smvm_pkg::OP_NAND: begin
            rf_we = 1'b1;
            rf_wd = ~(rb & rc);
          end
          smvm_pkg::OP_MAP: begin
            len_we = map_ok;
            rf_we  = map_ok;
            rf_wa  = fb;
            rf_wd  = {{(DW-SB){1'b0}}, new_id};
          end
          smvm_pkg::OP_UNMAP: begin
            stk_we = !unmap_bad;
          end
          smvm_pkg::OP_IN: begin
            rf_we = 1'b1;
            rf_wa = fc_idx;
            rf_wd = a_eof ? ~'0 : {{(DW-8){1'b0}}, a_byte};
          end
          smvm_pkg::OP_LOADVAL: begin
            rf_we = 1'b1;
            rf_wa = instr[27:25];
            rf_wd = {{(DW-25){1'b0}}, instr[24:0]};
          end
          default: begin
          end
        endcase
      end
      S_LOADW: begin
        rf_we = 1'b1;
        rf_wd = ram_q;
      end
      S_DIVW: begin
        rf_we = div_stat.done;
        rf_wd = div_quot;
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = {map_id, cnt[OB-1:0]};
      end
      S_COPY: begin
        ram_raddr = {src, cnt[OB-1:0]};
        ram_we    = cp_pend;
        ram_waddr = {{SB{1'b0}}, wcnt};
        ram_wdata = ram_q;
      end
      default: begin
      end
    endcase
  end

  smvm_ram #(.WIDTH(DW), .AW(AB)) u_word_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_q)
  );

  smvm_ram #(.WIDTH(LB), .AW(SB)) u_len_ram (
    .clk(clk), .we(len_we), .waddr(len_waddr), .wdata(len_wdata),
    .raddr(len_raddr), .rdata(len_q)
  );

  smvm_ram #(.WIDTH(SB), .AW(SB)) u_free_stack (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_q)
  );

  smvm_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(rb), .divisor(rc),
    .quot(div_quot), .stat(div_stat)
  );

  // register file: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < smvm_pkg::NUM_REGS; i++) begin
        rf[i] <= '0;
      end
    end else if (rf_we) begin
      rf[rf_wa] <= rf_wd;
    end
  end

  always_ff @(posedge clk) begin
    rf_q0 <= rf[rf_ra0];
    rf_q1 <= rf[rf_ra1];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pc        <= '0;
      pl        <= '0;
      run       <= smvm_pkg::ST_RUN;
      created   <= CB'(1);
      fc        <= '0;
      mapped    <= {{(smvm_pkg::MAX_SEGMENTS-1){1'b0}}, 1'b1};
      cp_pend   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && !res_stall && !out_load) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            a_byte  <= in_byte;
            a_eof   <= in_eof;
            item_ov <= 1'b0;
            item_ob <= '0;
            item_tk <= 1'b0;
            if (!action) begin
              if (pl < LB'(smvm_pkg::SEG_WORDS)) begin
                pl <= pl + 1'b1;
              end
              state <= S_DONE;
            end else if (run != smvm_pkg::ST_RUN) begin
              state <= S_DONE;
            end else if (pc >= {{(DW-LB){1'b0}}, pl}) begin
              run   <= smvm_pkg::ST_END;
              state <= S_DONE;
            end else begin
              state <= S_DEC;
            end
          end
        end
        S_DEC: begin
          instr <= ram_q;
          pc    <= pc + 1'b1;
          state <= S_OPND;
        end
        S_OPND: begin
          rb    <= rf_q0;
          rc    <= rf_q1;
          state <= S_LEN;
        end
        S_LEN: begin
          ra    <= rf_q0;
          state <= S_EXEC;
        end
        S_EXEC: begin
          state <= exec_next;
          case (op)
            smvm_pkg::OP_LOAD: begin
              if (!in_bnd) begin
                run <= smvm_pkg::ST_FAULT;
              end
            end
            smvm_pkg::OP_STORE: begin
              if (!in_bnd) begin
                run <= smvm_pkg::ST_FAULT;
              end
            end
            smvm_pkg::OP_DIV: begin
              if (rc == '0) begin
                run <= smvm_pkg::ST_FAULT;
              end
            end
            smvm_pkg::OP_HALT: begin
              run <= smvm_pkg::ST_HALT;
            end
            smvm_pkg::OP_MAP: begin
              if (map_ok) begin
                if (fc != '0) begin
                  fc <= fc - 1'b1;
                end else begin
                  created <= created + 1'b1;
                end
                mapped[new_id] <= 1'b1;
                map_id         <= new_id;
                xfer_len       <= rc[LB-1:0];
                cnt            <= '0;
              end else begin
                run <= smvm_pkg::ST_FAULT;
              end
            end
            smvm_pkg::OP_UNMAP: begin
              if (unmap_bad) begin
                run <= smvm_pkg::ST_FAULT;
              end else begin
                mapped[rc[SB-1:0]] <= 1'b0;
                fc                 <= fc + 1'b1;
              end
            end
            smvm_pkg::OP_OUT: begin
              item_ov <= 1'b1;
              item_ob <= rc[7:0];
            end
            smvm_pkg::OP_IN: begin
              item_tk <= !a_eof;
            end
            smvm_pkg::OP_LOADPRG: begin
              if (rb == '0) begin
                pc <= rc;
              end else if ((rb[DW-1:SB] != '0) || !mapped[rb[SB-1:0]]) begin
                run <= smvm_pkg::ST_FAULT;
              end else begin
                src      <= rb[SB-1:0];
                xfer_len <= len_q;
                pl       <= len_q;
                pc       <= rc;
                cnt      <= '0;
                cp_pend  <= 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
        S_LOADW: begin
          state <= S_DONE;
        end
        S_DIVW: begin
          if (div_stat.done) begin
            state <= S_DONE;
          end
        end
        S_FILL: begin
          cnt <= cnt + 1'b1;
          if (cnt + 1'b1 == xfer_len) begin
            state <= S_DONE;
          end
        end
        S_COPY: begin
          // read word cnt of the source, write the previous word into segment 0
          if (cnt < xfer_len) begin
            cnt     <= cnt + 1'b1;
            wcnt    <= cnt[OB-1:0];
            cp_pend <= 1'b1;
          end else begin
            cp_pend <= 1'b0;
            if (!cp_pend) begin
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (out_load) begin
            status    <= run;
            out_valid <= item_ov;
            out_byte  <= item_ob;
            in_taken  <= item_tk;
            next_pc   <= pc;
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // once stopped, the machine stays stopped until reset
  assert property (@(posedge clk) disable iff (rst)
    (run != smvm_pkg::ST_RUN) |=> (run == $past(run)))
    else $error("run status left a stopped state");

  // free identifiers never outnumber those handed out
  assert property (@(posedge clk) disable iff (rst) fc < created)
    else $error("free stack deeper than allocated identifiers");

  // divider finishes only while the sequencer waits for it
  assert property (@(posedge clk) disable iff (rst) div_stat.done |-> (state == S_DIVW))
    else $error("divider result with no divide pending");

  // program length stays within one segment
  assert property (@(posedge clk) disable iff (rst) pl <= LB'(smvm_pkg::SEG_WORDS))
    else $error("program length beyond segment size");
endmodule

@@ test/segmented_memory_vm_checker.sv @@
// Checker for the machine core: predicts each result and compares it at the result channel.
`timescale 1ns / 1ps
module segmented_memory_vm_checker
  import smvm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        action,
  input  logic [31:0] program_word,
  input  logic [7:0]  in_byte,
  input  logic        in_eof,
  input  logic        res_valid,
  input  logic        res_stall,
  input  logic [1:0]  status,
  input  logic        out_valid,
  input  logic [7:0]  out_byte,
  input  logic        in_taken,
  input  logic [31:0] next_pc,
  output int          fails,
  output int          pending
);

  typedef struct packed {
    logic [1:0]  status;
    logic        out_valid;
    logic [7:0]  out_byte;
    logic        in_taken;
    logic [31:0] next_pc;
  } vm_result_t;

  vm_result_t  due_q[$];

  // Shadow machine state
  logic [31:0] regs [NUM_REGS];
  logic [31:0] pc;
  int unsigned prog_len;
  logic [31:0] mem [MAX_SEGMENTS*SEG_WORDS];
  int unsigned seg_len [MAX_SEGMENTS];
  logic        seg_live [MAX_SEGMENTS];
  int unsigned seg_made;
  int unsigned free_ids [MAX_SEGMENTS];
  int unsigned free_cnt;
  logic [1:0]  run_st;

  initial begin
    fails = 0;
    pending = 0;
    for (int i = 0; i < NUM_REGS; i++) regs[i] = '0;
    for (int i = 0; i < MAX_SEGMENTS; i++) begin
      seg_len[i] = 0;
      seg_live[i] = 1'b0;
    end
    seg_live[0] = 1'b1;
    pc = '0;
    prog_len = 0;
    seg_made = 1;
    free_cnt = 0;
    run_st = ST_RUN;
  end

  function automatic logic seg_ok(logic [31:0] seg, logic [31:0] off);
    if (seg >= MAX_SEGMENTS || !seg_live[seg]) return 1'b0;
    return off < seg_len[seg];
  endfunction

  // Execute one transfer on the shadow state and return the expected result
  function automatic vm_result_t exec_item(logic act, logic [31:0] pw, logic [7:0] ib,
                                           logic eof);
    vm_result_t  r;
    logic [31:0] w, ra, rb, rc;
    logic [3:0]  op;
    logic [2:0]  a, b, c;
    int unsigned id, len;
    r = '0;
    if (!act) begin
      if (prog_len < SEG_WORDS) begin
        mem[prog_len] = pw;
        prog_len++;
        seg_len[0] = prog_len;
      end
    end else if (run_st == ST_RUN) begin
      if (pc >= prog_len) begin
        run_st = ST_END;
      end else begin
        w  = mem[pc[15:0]];
        op = w[31:28];
        a  = w[8:6];
        b  = w[5:3];
        c  = w[2:0];
        ra = regs[a];
        rb = regs[b];
        rc = regs[c];
        pc++;
        case (op)
          OP_CMOV: if (rc != 0) regs[a] = rb;
          OP_LOAD: begin
            if (seg_ok(rb, rc)) regs[a] = mem[rb * SEG_WORDS + rc];
            else run_st = ST_FAULT;
          end
          OP_STORE: begin
            if (seg_ok(ra, rb)) mem[ra * SEG_WORDS + rb] = rc;
            else run_st = ST_FAULT;
          end
          OP_ADD:  regs[a] = rb + rc;
          OP_MUL:  regs[a] = rb * rc;
          OP_DIV: begin
            if (rc != 0) regs[a] = rb / rc;
            else run_st = ST_FAULT;
          end
          OP_NAND: regs[a] = ~(rb & rc);
          OP_HALT: run_st = ST_HALT;
          OP_MAP: begin
            id = 0;
            if (rc > SEG_WORDS) begin
              run_st = ST_FAULT;
            end else if (free_cnt > 0) begin
              free_cnt--;
              id = free_ids[free_cnt] % MAX_SEGMENTS;
            end else if (seg_made < MAX_SEGMENTS) begin
              id = seg_made;
              seg_made++;
            end else begin
              run_st = ST_FAULT;
            end
            if (run_st == ST_RUN) begin
              for (int i = 0; i < rc; i++) mem[id * SEG_WORDS + i] = '0;
              seg_len[id] = rc;
              seg_live[id] = 1'b1;
              regs[b] = id;
            end
          end
          OP_UNMAP: begin
            if (rc == 0 || rc >= MAX_SEGMENTS || !seg_live[rc] || free_cnt >= MAX_SEGMENTS) begin
              run_st = ST_FAULT;
            end else begin
              seg_live[rc] = 1'b0;
              seg_len[rc] = 0;
              free_ids[free_cnt] = rc;
              free_cnt++;
            end
          end
          OP_OUT: begin
            r.out_valid = 1'b1;
            r.out_byte = rc[7:0];
          end
          OP_IN: begin
            if (eof) begin
              regs[c] = '1;
            end else begin
              regs[c] = {24'd0, ib};
              r.in_taken = 1'b1;
            end
          end
          OP_LOADPRG: begin
            if (rb != 0 && (rb >= MAX_SEGMENTS || !seg_live[rb])) begin
              run_st = ST_FAULT;
            end else begin
              if (rb != 0) begin
                // ascending copy is safe, source lies above segment 0
                len = seg_len[rb];
                for (int i = 0; i < len; i++) mem[i] = mem[rb * SEG_WORDS + i];
                prog_len = len;
                seg_len[0] = len;
              end
              pc = rc;
            end
          end
          OP_LOADVAL: regs[w[27:25]] = {7'd0, w[24:0]};
          default: ;
        endcase
      end
    end
    r.status = run_st;
    r.next_pc = pc;
    return r;
  endfunction

  // Compare finished results first, then record the new transfer
  always @(posedge clk) begin
    vm_result_t got, want;
    if (!rst) begin
      if (res_valid && !res_stall) begin
        got = '{status, out_valid, out_byte, in_taken, next_pc};
        if (due_q.size() == 0) begin
          $error("result transfer with nothing expected");
          fails++;
        end else begin
          want = due_q.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fails++;
          end
          if (got.out_valid !== want.out_valid) begin
            $error("out_valid: expected %0d, got %0d", want.out_valid, got.out_valid);
            fails++;
          end
          if (got.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
            fails++;
          end
          if (got.in_taken !== want.in_taken) begin
            $error("in_taken: expected %0d, got %0d", want.in_taken, got.in_taken);
            fails++;
          end
          if (got.next_pc !== want.next_pc) begin
            $error("next_pc: expected %0h, got %0h", want.next_pc, got.next_pc);
            fails++;
          end
        end
      end
      if (in_valid && !in_stall)
        due_q.push_back(exec_item(action, program_word, in_byte, in_eof));
      pending <= due_q.size();
    end
  end

endmodule

@@ test/segmented_memory_vm_core_tb.sv @@
// Testbench top for the machine core: builds instruction streams and reports the verdict.
`timescale 1ns / 1ps
module segmented_memory_vm_core_tb;
  import smvm_pkg::*;

  localparam int CYCLE_LIMIT = 10000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        action = 1'b0;
  logic [31:0] program_word = '0;
  logic [7:0]  in_byte = '0;
  logic        in_eof = 1'b0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic [1:0]  status;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic        in_taken;
  logic [31:0] next_pc;
  int          fails;
  int          pending;

  int          send_idle_pct = 21;
  int          recv_idle_pct = 62;
  int          cycles = 0;
  int          items_sent = 0;
  int          steps_sent = 0;

  // Stimulus-side view of segment allocation and program length
  int          prog_len = 0;
  int          seg_made = 1;
  int          live_ids[$];
  int          free_ids[$];
  int          seg_size [MAX_SEGMENTS];

  segmented_memory_vm_core i_dut (.*);

  segmented_memory_vm_checker i_check (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  // Receiver stalls at random
  always @(posedge clk) begin
    res_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Run time guard
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send(logic act, logic [31:0] w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    action       <= act;
    program_word <= w;
    in_byte      <= 8'($urandom);
    in_eof       <= ($urandom_range(0, 3) == 0);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (act) steps_sent++;
  endtask

  // Append one instruction and execute it straight away
  task automatic emit(logic [31:0] w);
    send(1'b0, w);
    if (prog_len < SEG_WORDS) prog_len++;
    send(1'b1, $urandom);
  endtask

  function automatic logic [31:0] mk(logic [3:0] op, logic [2:0] a, logic [2:0] b,
                                     logic [2:0] c);
    return {op, 19'($urandom), a, b, c};
  endfunction

  task automatic set_reg(logic [2:0] r, logic [24:0] v);
    emit({OP_LOADVAL, r, v});
  endtask

  task automatic do_map(int size);
    logic [2:0] b, c;
    int id;
    if (free_ids.size() == 0 && seg_made >= MAX_SEGMENTS) return;
    c = 3'($urandom);
    b = c + 3'($urandom_range(1, 7));
    set_reg(c, size);
    emit(mk(OP_MAP, 3'($urandom), b, c));
    if (free_ids.size() > 0) begin
      id = free_ids.pop_back();
    end else begin
      id = seg_made;
      seg_made++;
    end
    seg_size[id] = size;
    live_ids.push_back(id);
  endtask

  task automatic do_unmap();
    logic [2:0] c;
    int k, id;
    // the first two segments stay mapped; the second one is empty and serves reloads
    if (live_ids.size() <= 2) return;
    k = $urandom_range(2, live_ids.size() - 1);
    id = live_ids[k];
    live_ids.delete(k);
    c = 3'($urandom);
    set_reg(c, id);
    emit(mk(OP_UNMAP, 3'($urandom), 3'($urandom), c));
    free_ids.push_back(id);
  endtask

  // Load or store at a random in-range location
  task automatic do_mem(logic is_store);
    logic [2:0] p, q;
    int id, len;
    id = ($urandom_range(0, 2) == 0) ? 0 : live_ids[$urandom_range(0, live_ids.size() - 1)];
    len = (id == 0) ? prog_len : seg_size[id];
    if (len == 0) return;
    p = 3'($urandom);
    q = p + 3'($urandom_range(1, 7));
    set_reg(p, id);
    set_reg(q, $urandom_range(0, len - 1));
    if (is_store) emit(mk(OP_STORE, p, q, 3'($urandom)));
    else emit(mk(OP_LOAD, 3'($urandom), p, q));
  endtask

  // Load program: from segment 0 it is a jump to the next word to be appended;
  // from another segment only short ones are taken so the program store keeps room
  task automatic do_jump(logic from_seg);
    logic [2:0] b, c;
    int id, t;
    b = 3'($urandom);
    c = b + 3'($urandom_range(1, 7));
    if (from_seg) begin
      do begin
        id = live_ids[$urandom_range(1, live_ids.size() - 1)];
      end while (seg_size[id] > 900);
      set_reg(b, id);
      set_reg(c, seg_size[id]);
      emit(mk(OP_LOADPRG, 3'($urandom), b, c));
      prog_len = seg_size[id];
    end else begin
      set_reg(b, 0);
      t = prog_len + 2;
      set_reg(c, t);
      emit(mk(OP_LOADPRG, 3'($urandom), b, c));
    end
  endtask

  task automatic do_div();
    logic [2:0] c;
    c = 3'($urandom);
    set_reg(c, $urandom_range(1, 25'h1ffffff));
    emit(mk(OP_DIV, 3'($urandom), 3'($urandom), c));
  endtask

  task automatic random_op();
    int pick;
    if (prog_len > 990) begin
      do_jump(1'b1);
      return;
    end
    pick = $urandom_range(0, 99);
    if (pick < 12) emit(mk(OP_CMOV, 3'($urandom), 3'($urandom), 3'($urandom)));
    else if (pick < 22) emit(mk(OP_ADD, 3'($urandom), 3'($urandom), 3'($urandom)));
    else if (pick < 30) emit(mk(OP_MUL, 3'($urandom), 3'($urandom), 3'($urandom)));
    else if (pick < 38) emit(mk(OP_NAND, 3'($urandom), 3'($urandom), 3'($urandom)));
    else if (pick < 44) do_div();
    else if (pick < 54) set_reg(3'($urandom), 25'($urandom));
    else if (pick < 60) do_mem(1'b0);
    else if (pick < 66) do_mem(1'b1);
    else if (pick < 71) do_map(($urandom_range(0, 9) == 0) ? SEG_WORDS : $urandom_range(0, 12));
    else if (pick < 75) do_unmap();
    else if (pick < 82) emit(mk(OP_OUT, 3'($urandom), 3'($urandom), 3'($urandom)));
    else if (pick < 89) emit(mk(OP_IN, 3'($urandom), 3'($urandom), 3'($urandom)));
    else if (pick < 92) do_jump(1'b0);
    else if (pick < 94) do_jump(1'b1);
    else emit({($urandom_range(0, 1) ? 4'd14 : 4'd15), 28'($urandom)});
  endtask

  // Stopping instruction, chosen at random since the machine never restarts
  task automatic stop_machine();
    logic [2:0] b, c;
    b = 3'($urandom);
    c = b + 3'($urandom_range(1, 7));
    case ($urandom_range(0, 6))
      0: emit(mk(OP_HALT, 3'($urandom), 3'($urandom), 3'($urandom)));
      1: begin
        set_reg(c, 0);
        emit(mk(OP_DIV, 3'($urandom), b, c));
      end
      2: begin
        set_reg(b, 100);
        emit(mk(OP_LOAD, 3'($urandom), b, c));
      end
      3: begin
        set_reg(c, SEG_WORDS + 1);
        emit(mk(OP_MAP, 3'($urandom), b, c));
      end
      4: begin
        set_reg(c, 0);
        emit(mk(OP_UNMAP, 3'($urandom), b, c));
      end
      5: begin
        set_reg(b, 70);
        emit(mk(OP_LOADPRG, 3'($urandom), b, c));
      end
      default: send(1'b1, $urandom);
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int target;
    int start;
    int proj;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes and each instruction but halt
    emit(32'h0000_0000);
    emit(32'hffff_ffff);
    do_map(SEG_WORDS);
    do_map(0);
    do_map(1);
    set_reg(3'd1, 25'h1ff_ffff);
    emit(mk(OP_MUL, 3'd2, 3'd1, 3'd1));
    emit(mk(OP_ADD, 3'd3, 3'd2, 3'd1));
    emit(mk(OP_NAND, 3'd4, 3'd3, 3'd3));
    emit(mk(OP_OUT, 3'd0, 3'd0, 3'd4));
    emit(mk(OP_IN, 3'd0, 3'd0, 3'd5));
    do_div();
    do_mem(1'b1);
    do_mem(1'b0);
    do_jump(1'b0);
    do_unmap();
    drain();

    // Random: three idling phases with a full drain between them; the length counts
    // the appends still needed to fill the program store at the end
    target = 1680;
    start = items_sent + SEG_WORDS - prog_len;
    proj = start;
    while (proj < target) begin
      random_op();
      proj = items_sent + SEG_WORDS - prog_len;
      if (send_idle_pct == 21 && proj > start + (target - start) / 3) begin
        drain();
        send_idle_pct = 62;
        recv_idle_pct = 21;
      end else if (send_idle_pct == 62 && proj > start + 2 * (target - start) / 3) begin
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    end

    // Stop the machine, check stopped steps, then fill the program store
    stop_machine();
    repeat (4) send(1'b1, $urandom);
    repeat (SEG_WORDS - prog_len + 3) send(1'b0, $urandom);
    send(1'b1, $urandom);

    drain();
    repeat (60) @(posedge clk);
    $display("Sent %0d transfers, %0d of them steps; final machine status %0d.",
             items_sent, steps_sent, status);
    if (fails == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/smvm_pkg.sv
src/smvm_ram.sv
src/smvm_div.sv
src/segmented_memory_vm_core.sv
test/segmented_memory_vm_checker.sv
test/segmented_memory_vm_core_tb.sv
